FILE: hw/rtl/pdfc_pkg.sv
// ----------------------------------------------------------------------------
// pdfc_pkg
// shared types and constants of the pll divider factor calculator
// ----------------------------------------------------------------------------
`default_nettype none

package pdfc_pkg;

  localparam int unsigned FreqW       = 32;
  localparam int unsigned IntW        = 4;
  localparam int unsigned FracW       = 24;
  localparam int unsigned FracBitsDef = 24;
  localparam int unsigned FracBitsMin = 16;
  localparam int unsigned FracBitsMax = 28;
  localparam logic [FreqW-1:0] NMin   = 32'd6;
  localparam logic [FreqW-1:0] NMax   = 32'd12;

  typedef struct packed {
    logic             bad;
    logic [FreqW-1:0] tgt;
    logic [FreqW-1:0] dvs;
    logic             pre;
  } job_t;

endpackage : pdfc_pkg

`default_nettype wire

FILE: hw/rtl/pdfc_divider.sv
// ----------------------------------------------------------------------------
// pdfc_divider
// restoring radix-2 divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module pdfc_divider
  import pdfc_pkg::*;
#(
  parameter int unsigned NumW = 64,
  parameter int unsigned DenW = 32
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [NumW-1:0] num_i,
  input  wire logic [DenW-1:0] den_i,
  output logic                 busy_o,
  output logic                 done_o,
  output logic [NumW-1:0]      quo_o,
  output logic [DenW-1:0]      rem_o
);

  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [CntW-1:0] cnt_q;
  logic            busy_q, done_q;
  logic [NumW-1:0] quo_q;
  logic [DenW:0]   rem_q;
  logic [DenW-1:0] den_q;
  logic [DenW:0]   shf;
  logic [DenW:0]   dif;

  assign shf = {rem_q[DenW-1:0], quo_q[NumW-1]};
  assign dif = shf - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(NumW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      if (!dif[DenW]) begin
        rem_q <= dif;
        quo_q <= {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_q <= shf;
        quo_q <= {quo_q[NumW-2:0], 1'b0};
      end
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q[DenW-1:0];

endmodule : pdfc_divider

`default_nettype wire

FILE: hw/rtl/pdfc_front.sv
// ----------------------------------------------------------------------------
// pdfc_front
// accepts requests, resolves prescale with a first division, queues jobs
// ----------------------------------------------------------------------------
`default_nettype none

module pdfc_front
  import pdfc_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [FreqW-1:0] target_freq_i,
  input  wire logic [FreqW-1:0] ref_freq_i,
  output logic                  job_valid_o,
  input  wire logic             job_stall_i,
  output job_t                  job_o
);

  typedef enum logic [1:0] {StIdle, StDiv, StPush} state_e;

  state_e           state_q;
  logic [FreqW-1:0] tgt_q, ref_q;
  job_t             job_q;
  logic             dv_start, dv_busy, dv_done;
  logic [FreqW-1:0] dv_quo, dv_rem;
  logic             acc;

  // two-entry queue
  job_t             fifo_q [2];
  logic             wptr_q, rptr_q;
  logic [1:0]       cnt_q;
  logic             push, pop;

  assign acc        = in_valid_i && (state_q == StIdle);
  assign in_stall_o = (state_q != StIdle);
  assign dv_start   = acc && (ref_freq_i != '0);

  pdfc_divider #(.NumW(FreqW), .DenW(FreqW)) u_div (
    .clk_i, .rst_ni,
    .start_i(dv_start), .num_i(target_freq_i), .den_i(ref_freq_i),
    .busy_o(dv_busy), .done_o(dv_done), .quo_o(dv_quo), .rem_o(dv_rem)
  );

  assign push = (state_q == StPush) && (cnt_q != 2'd2);
  assign pop  = job_valid_o && !job_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        StIdle: if (acc) state_q <= (ref_freq_i == '0) ? StPush : StDiv;
        StDiv:  if (dv_done) state_q <= StPush;
        StPush: if (push) state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
      if (push) wptr_q <= ~wptr_q;
      if (pop) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      tgt_q     <= target_freq_i;
      ref_q     <= ref_freq_i;
      job_q.bad <= (ref_freq_i == '0);
      job_q.tgt <= target_freq_i;
      job_q.dvs <= ref_freq_i;
      job_q.pre <= 1'b0;
    end else if (dv_done && dv_quo < NMin) begin
      job_q.pre <= 1'b1;
      job_q.dvs <= {1'b0, ref_q[FreqW-1:1]};
      job_q.bad <= (ref_q[FreqW-1:1] == '0);
    end
    if (push) fifo_q[wptr_q] <= job_q;
  end

  assign job_valid_o = (cnt_q != '0);
  assign job_o       = fifo_q[rptr_q];

  logic unused;
  assign unused = ^{dv_busy, dv_rem, tgt_q};

endmodule : pdfc_front

`default_nettype wire

FILE: hw/rtl/pdfc_back.sv
// ----------------------------------------------------------------------------
// pdfc_back
// final quotient, scaled fraction division and decimal rounding
// ----------------------------------------------------------------------------
`default_nettype none

module pdfc_back
  import pdfc_pkg::*;
#(
  parameter int unsigned FracBits = FracBitsDef
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            job_valid_i,
  output logic                 job_stall_o,
  input  job_t                 job_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output logic                 prescale_o,
  output logic [IntW-1:0]      int_div_o,
  output logic [FracW-1:0]     frac_div_o,
  output logic                 range_warn_o,
  output logic                 div_error_o
);

  localparam int unsigned NumW = FreqW + FracBits + 4;

  typedef enum logic [2:0] {StIdle, StQ, StK, StRnd, StOut} state_e;

  state_e             state_q;
  job_t               job_q;
  logic [FreqW-1:0]   q_q;
  logic               warn_q;
  logic [FreqW-1:0]   k_q;
  logic [FreqW-1:0]   k_rnd;
  logic [2*FreqW-1:0] k_prod;
  logic [FreqW-1:0]   k_div;

  logic             s1, b1, d1, s2, b2, d2;
  logic [FreqW-1:0] q1, r1, r2;
  logic [NumW-1:0]  q2, num2;

  logic             pre_q, warn_o_q, err_q;
  logic [IntW-1:0]  n_q;
  logic [FracW-1:0] k_out_q;

  assign job_stall_o = (state_q != StIdle);
  assign s1 = job_valid_i && (state_q == StIdle) && !job_i.bad;
  assign s2 = (state_q == StQ) && d1;
  assign num2 = NumW'(r1) * NumW'(10) << FracBits;

  pdfc_divider #(.NumW(FreqW), .DenW(FreqW)) u_div_q (
    .clk_i, .rst_ni, .start_i(s1), .num_i(job_i.tgt), .den_i(job_i.dvs),
    .busy_o(b1), .done_o(d1), .quo_o(q1), .rem_o(r1)
  );

  pdfc_divider #(.NumW(NumW), .DenW(FreqW)) u_div_k (
    .clk_i, .rst_ni, .start_i(s2), .num_i(num2), .den_i(job_q.dvs),
    .busy_o(b2), .done_o(d2), .quo_o(q2), .rem_o(r2)
  );

  // round half up on the last digit, then divide by 10 via reciprocal
  assign k_rnd  = k_q + FreqW'(5);
  assign k_prod = (2*FreqW)'(k_rnd) * (2*FreqW)'(32'hCCCC_CCCD);
  assign k_div  = FreqW'(k_prod >> 35);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      unique case (state_q)
        StIdle: if (job_valid_i) state_q <= job_i.bad ? StOut : StQ;
        StQ:    if (d1) state_q <= StK;
        StK:    if (d2) state_q <= StRnd;
        StRnd:  state_q <= StOut;
        StOut:  if (!out_stall_i) state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_valid_i && state_q == StIdle) begin
      job_q   <= job_i;
      pre_q   <= 1'b0;
      n_q     <= '0;
      k_out_q <= '0;
      warn_o_q <= 1'b0;
      err_q   <= job_i.bad;
    end
    if (d1) begin
      q_q    <= q1;
      warn_q <= (q1 < NMin) || (q1 > NMax);
    end
    if (d2) k_q <= q2[FreqW-1:0];
    if (state_q == StRnd) begin
      pre_q    <= job_q.pre;
      n_q      <= q_q[IntW-1:0];
      warn_o_q <= warn_q;
      k_out_q  <= FracW'(k_div & ((FreqW'(1) << FracBits) - FreqW'(1)));
    end
  end

  assign out_valid_o  = (state_q == StOut);
  assign prescale_o   = pre_q;
  assign int_div_o    = n_q;
  assign frac_div_o   = k_out_q;
  assign range_warn_o = warn_o_q;
  assign div_error_o  = err_q;

  logic unused;
  assign unused = ^{b1, b2, r2, q2[NumW-1:FreqW], k_prod[34:0]};

endmodule : pdfc_back

`default_nettype wire

FILE: hw/rtl/pll_divider_factor_calc_core.sv
// path: each request passes the front (32-bit division, queue push) and then
// the back (32-bit and 60-bit divisions) before its result is valid
// throughput: set by the back, which takes a new job only when idle; zero-divisor
// requests skip the divisions; the two-entry job queue lets the front run ahead
// reset: rst_ni asynchronous active low, clears all control state and the queue
// ----------------------------------------------------------------------------
// pll_divider_factor_calc_core
// fractional-n pll divider factor calculator
// ----------------------------------------------------------------------------
`default_nettype none

module pll_divider_factor_calc_core
  import pdfc_pkg::*;
#(
  parameter int unsigned FracBits = FracBitsDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [FreqW-1:0] target_freq_i,
  input  wire logic [FreqW-1:0] ref_freq_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic                  prescale_o,
  output logic [IntW-1:0]       int_div_o,
  output logic [FracW-1:0]      frac_div_o,
  output logic                  range_warn_o,
  output logic                  div_error_o
);

  logic job_valid, job_stall;
  job_t job;

  pdfc_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .target_freq_i, .ref_freq_i,
    .job_valid_o(job_valid), .job_stall_i(job_stall), .job_o(job)
  );

  pdfc_back #(.FracBits(FracBits)) u_back (
    .clk_i, .rst_ni, .job_valid_i(job_valid), .job_stall_o(job_stall), .job_i(job),
    .out_valid_o, .out_stall_i, .prescale_o, .int_div_o, .frac_div_o,
    .range_warn_o, .div_error_o
  );

`ifndef ASSERT_OFF
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && div_error_o |-> !prescale_o && int_div_o == '0 && frac_div_o == '0)
    else $error("error result not zeroed");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(int_div_o))
    else $error("stalled result changed");
`endif

endmodule : pll_divider_factor_calc_core

`default_nettype wire
